FILE: rtl/deque_with_listing_unit_assert.svh
// Assertion macros for the deque_with_listing_unit RTL.
// Clock clk_i and reset rst_ni are taken from the enclosing module.
`ifndef DEQUE_WITH_LISTING_UNIT_ASSERT_SVH
`define DEQUE_WITH_LISTING_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DWL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define DWL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DWL_ASSERT_IMP(lbl, ante, cons, msg)

`define DWL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/dwl_pkg.sv
package dwl_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned ItemWidth  = 32;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SWAP       = 3'd4,
    OP_LIST_FWD   = 3'd5,
    OP_LIST_BWD   = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

endpackage

FILE: rtl/dwl_mem.sv
module dwl_mem #(
  parameter int unsigned DEPTH      = dwl_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = dwl_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [DATA_WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [DATA_WIDTH-1:0]         rdata_o
);
  import dwl_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/deque_with_listing_unit.sv
// Channel   | Signals                                       | Handshake
// ----------+-----------------------------------------------+-------------------------------
// command   | opcode_i, value_i                             | start, taken when busy is low
// result    | item_o, last_o, empty_res_o, status_o         | valid_o, one cycle per transfer
//
// An operation is executed in the EXEC state and then listed entry by entry in the LIST
// state, or gives a single empty result when the queue ends empty; a swap on a nonempty
// queue passes through SWAP1, SWAP2 and SWAP3 first. One wrap adder forms every read address,
// and the single read port of the entry memory yields one listed entry per cycle. Reset clears
// pointers and sequencer; entry contents are not cleared.
// The receiver cannot stall: each result transfer is a single-cycle strobe on valid_o.
`include "deque_with_listing_unit_assert.svh"

module deque_with_listing_unit #(
  parameter int unsigned DEPTH      = dwl_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = dwl_pkg::DataWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          opcode_i,
  input  logic signed [dwl_pkg::ValueWidth-1:0] value_i,
  output logic                                valid_o,
  output logic signed [dwl_pkg::ItemWidth-1:0]  item_o,
  output logic                                last_o,
  output logic                                empty_res_o,
  output logic [1:0]                          status_o
);
  import dwl_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SWAP1 = 3'd2;
  localparam logic [2:0] S_SWAP2 = 3'd3;
  localparam logic [2:0] S_SWAP3 = 3'd4;
  localparam logic [2:0] S_LIST  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [IW-1:0]         head_q, head_d;
  logic [CW-1:0]         occ_q, occ_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [2:0]            op_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] tmp_q;
  logic [IW-1:0]         back_q;
  status_e               status_q, status_d;
  logic                  valid_q, valid_d;
  logic                  last_q, last_d;
  logic                  empty_q, empty_d;

  // shared ring address unit
  logic [CW-1:0]         offset;
  logic [SW-1:0]         sum;
  logic [IW-1:0]         pos;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] in_word;
  logic                  accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign sum = SW'(head_q) + SW'(offset);
  assign pos = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);

  generate
    if (DATA_WIDTH >= ValueWidth) begin : g_win
      assign in_word = DATA_WIDTH'(value_i);
    end else begin : g_wnarrow
      assign in_word = value_i[DATA_WIDTH-1:0];
    end
    if (DATA_WIDTH >= ItemWidth) begin : g_iwide
      assign item_o = empty_q ? '0 : rdata[ItemWidth-1:0];
    end else begin : g_inarrow
      assign item_o = empty_q ? '0
                    : {{(ItemWidth-DATA_WIDTH){rdata[DATA_WIDTH-1]}}, rdata};
    end
  endgenerate

  dwl_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (pos),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    occ_d    = occ_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    valid_d  = 1'b0;
    last_d   = 1'b0;
    empty_d  = 1'b0;
    offset   = '0;
    we       = 1'b0;
    waddr    = pos;
    wdata    = word_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        unique case (op_q)
          OP_PUSH_BACK: begin
            offset = occ_q;
            if (occ_q == CW'(DEPTH)) begin
              status_d = ST_OVERFLOW;
            end else begin
              we    = 1'b1;
              occ_d = occ_q + 1'b1;
            end
          end
          OP_POP_FRONT: begin
            offset = CW'(1);
            if (occ_q == '0) begin
              status_d = ST_UNDERFLOW;
            end else begin
              head_d = pos;
              occ_d  = occ_q - 1'b1;
            end
          end
          OP_PUSH_FRONT: begin
            offset = CW'(DEPTH - 1);
            if (occ_q == CW'(DEPTH)) begin
              status_d = ST_OVERFLOW;
            end else begin
              we     = 1'b1;
              head_d = pos;
              occ_d  = occ_q + 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (occ_q == '0) begin
              status_d = ST_UNDERFLOW;
            end else begin
              occ_d = occ_q - 1'b1;
            end
          end
          OP_SWAP: begin
            // offset zero: read the front entry
            if (occ_q == '0) begin
              status_d = ST_UNDERFLOW;
            end
          end
          default: begin
          end
        endcase
        cnt_d = '0;
        if (op_q == OP_SWAP && occ_q != '0) begin
          state_d = S_SWAP1;
        end else if (occ_d == '0) begin
          valid_d = 1'b1;
          last_d  = 1'b1;
          empty_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_LIST;
        end
      end
      S_SWAP1: begin
        // front word arrives, read the back entry
        offset  = occ_q - 1'b1;
        state_d = S_SWAP2;
      end
      S_SWAP2: begin
        we      = 1'b1;
        waddr   = head_q;
        wdata   = rdata;
        state_d = S_SWAP3;
      end
      S_SWAP3: begin
        we      = 1'b1;
        waddr   = back_q;
        wdata   = tmp_q;
        state_d = S_LIST;
      end
      S_LIST: begin
        offset  = (op_q == OP_LIST_BWD) ? (occ_q - 1'b1 - cnt_q) : cnt_q;
        valid_d = 1'b1;
        last_d  = (cnt_q == occ_q - 1'b1);
        cnt_d   = cnt_q + 1'b1;
        if (last_d) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      occ_q    <= '0;
      cnt_q    <= '0;
      status_q <= ST_OK;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
      empty_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
      empty_q  <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      word_q <= in_word;
    end
    if (state_q == S_SWAP1) begin
      tmp_q  <= rdata;
      back_q <= pos;
    end
  end

  assign valid_o     = valid_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;
  assign status_o    = status_q;

  `DWL_ASSERT_IMP(a_occ_range, 1'b1, occ_q <= CW'(DEPTH), "occupancy above depth")
  `DWL_ASSERT_NXT(a_last_gap, valid_o && last_o, !valid_o, "result right after final transfer")
  `DWL_ASSERT_NXT(a_accept_exec, accept, state_q == S_EXEC, "accepted command not executed")
  `DWL_ASSERT_IMP(a_empty_last, valid_o && empty_res_o, last_o && item_o == '0,
                  "empty result not final or nonzero")
  `DWL_ASSERT_IMP(a_ovf_full, state_q == S_EXEC && status_d == ST_OVERFLOW,
                  occ_q == CW'(DEPTH), "overflow flagged below depth")

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dwl_pkg::*;

  localparam int Depth        = DepthDef;
  localparam int DataWidth    = DataWidthDef;
  localparam int SettleCycles = 2 * (Depth + 5);
  localparam int CycleLimit   = 200000;

  // opcode seven has no meaning: it must list front to back and change nothing
  localparam logic [2:0] OP_UNDEFINED = 3'd7;

  typedef struct {
    logic signed [ItemWidth-1:0] item;
    logic                        last;
    logic                        empty;
    status_e                     status;
  } listing_entry_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic [2:0]                   opcode_i    = OP_LIST_FWD;
  logic signed [ValueWidth-1:0] value_i     = '0;
  logic                         busy;
  logic                         valid_o;
  logic signed [ItemWidth-1:0]  item_o;
  logic                         last_o;
  logic                         empty_res_o;
  logic [1:0]                   status_o;

  deque_with_listing_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .item_o      (item_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .status_o    (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted deque contents
  logic [DataWidth-1:0] ring [Depth];
  int                   head;
  int                   occ;

  listing_entry_t expected_listing[$];

  int error_count     = 0;
  int commands_sent   = 0;
  int results_seen    = 0;
  int overflow_hits   = 0;
  int underflow_hits  = 0;
  int peak_occupancy  = 0;
  int cycle_count     = 0;
  int sender_idle_pct = 0;

  // apply one command to the predicted deque and queue up the listing it produces
  function automatic void apply_and_list(logic [2:0] op, logic signed [ValueWidth-1:0] val);
    status_e                     st;
    int                          back;
    int                          pos;
    logic [DataWidth-1:0]        tmp;
    logic signed [DataWidth-1:0] word;
    listing_entry_t              e;
    st = ST_OK;
    case (op)
      OP_PUSH_BACK: begin
        if (occ >= Depth) st = ST_OVERFLOW;
        else begin
          ring[(head + occ) % Depth] = DataWidth'($unsigned(val));
          occ++;
        end
      end
      OP_POP_FRONT: begin
        if (occ == 0) st = ST_UNDERFLOW;
        else begin
          head = (head + 1) % Depth;
          occ--;
        end
      end
      OP_PUSH_FRONT: begin
        if (occ >= Depth) st = ST_OVERFLOW;
        else begin
          head = (head + Depth - 1) % Depth;
          ring[head] = DataWidth'($unsigned(val));
          occ++;
        end
      end
      OP_POP_BACK: begin
        if (occ == 0) st = ST_UNDERFLOW;
        else occ--;
      end
      OP_SWAP: begin
        if (occ == 0) st = ST_UNDERFLOW;
        else begin
          back = (head + occ - 1) % Depth;
          tmp = ring[head];
          ring[head] = ring[back];
          ring[back] = tmp;
        end
      end
      default: ;
    endcase

    if (st == ST_OVERFLOW) overflow_hits++;
    if (st == ST_UNDERFLOW) underflow_hits++;
    if (occ > peak_occupancy) peak_occupancy = occ;

    if (occ == 0) begin
      e.item   = '0;
      e.last   = 1'b1;
      e.empty  = 1'b1;
      e.status = st;
      expected_listing.push_back(e);
    end else begin
      for (int k = 0; k < occ; k++) begin
        pos      = (op == OP_LIST_BWD) ? occ - 1 - k : k;
        word     = ring[(head + pos) % Depth];
        e.item   = ItemWidth'(word);
        e.last   = (k + 1 == occ);
        e.empty  = 1'b0;
        e.status = st;
        expected_listing.push_back(e);
      end
    end
  endfunction

  function automatic int draw_gap();
    int g;
    g = 0;
    while (g < 64 && $urandom_range(99) < sender_idle_pct) g++;
    return g;
  endfunction

  function automatic logic signed [ValueWidth-1:0] draw_value();
    case ($urandom_range(7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    case ($urandom_range(3))
      0:       return OP_SWAP;
      1:       return OP_LIST_FWD;
      2:       return OP_LIST_BWD;
      default: return OP_UNDEFINED;
    endcase
  endfunction

  // entered and left at a rising edge; start stays high after the transfer
  task automatic send_command(logic [2:0] op, logic signed [ValueWidth-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    opcode_i <= op;
    value_i  <= val;
    do @(posedge clk_i); while (busy);
    apply_and_list(op, val);
    commands_sent++;
  endtask

  task automatic wait_for_listings();
    start <= 1'b0;
    while (expected_listing.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_command(OP_LIST_FWD, 32'sh1234_5678);
    send_command(OP_LIST_BWD, -32'sd1);
    send_command(OP_POP_FRONT, '0);
    send_command(OP_POP_BACK, 32'sh7fff_ffff);
    send_command(OP_SWAP, 32'sh8000_0000);
    send_command(OP_UNDEFINED, -32'sd1);
  endtask

  task automatic test_single_entry();
    send_command(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_command(OP_SWAP, '0);
    send_command(OP_LIST_BWD, '0);
    send_command(OP_POP_FRONT, '0);
    send_command(OP_PUSH_FRONT, 32'sh8000_0000);
    send_command(OP_POP_BACK, -32'sd1);
  endtask

  task automatic test_both_ends();
    send_command(OP_PUSH_BACK, -32'sd1);
    send_command(OP_PUSH_FRONT, '0);
    send_command(OP_PUSH_BACK, 32'sh5555_5555);
    send_command(OP_PUSH_FRONT, 32'shaaaa_aaaa);
    send_command(OP_SWAP, '0);
    send_command(OP_LIST_BWD, '0);
    send_command(OP_UNDEFINED, 32'sh0f0f_0f0f);
    send_command(OP_POP_FRONT, '0);
    send_command(OP_POP_BACK, '0);
    send_command(OP_POP_BACK, '0);
    send_command(OP_POP_FRONT, '0);
  endtask

  // push-heavy stretch runs into overflow, pop-heavy stretch drains toward empty
  task automatic test_random_traffic(int idle_pct, int n);
    logic [2:0] op;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      if (i < n * 3 / 5) op = pick_op(80, 10);
      else op = pick_op(10, 75);
      send_command(op, draw_value());
    end
  endtask

  always @(posedge clk_i) begin : check_results
    listing_entry_t want;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (expected_listing.size() == 0) begin
        $error("unexpected result: item %0d last %0b empty %0b status %0d",
               item_o, last_o, empty_res_o, status_o);
        error_count++;
      end else begin
        want = expected_listing.pop_front();
        if (item_o !== want.item) begin
          $error("item: expected %0d, got %0d", want.item, item_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
        if (empty_res_o !== want.empty) begin
          $error("empty_res: expected %0b, got %0b", want.empty, empty_res_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timed out after %0d cycles, %0d results outstanding",
             cycle_count, expected_listing.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    head = 0;
    occ  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_single_entry();
    test_both_ends();
    wait_for_listings();

    test_random_traffic(0, 34);
    wait_for_listings();
    test_random_traffic(88, 34);
    wait_for_listings();
    test_random_traffic(0, 34);
    wait_for_listings();
    test_random_traffic(7, 34);
    wait_for_listings();

    $display("%0d commands, %0d listed results checked, peak occupancy %0d of %0d",
             commands_sent, results_seen, peak_occupancy, Depth);
    $display("overflow on full push %0d times, underflow on empty pop or swap %0d times",
             overflow_hits, underflow_hits);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
